FILE: hdl/tmr_pkg.sv
// Shared types, widths and codes of the triangle mask rasterizer.
package tmr_pkg;

    // Fixed field widths.
    localparam int CMD_W     = 2;
    localparam int COORD_W   = 24;
    localparam int POS_W     = 32;
    localparam int HALF_W    = 24;
    localparam int TPM_W     = 32;
    localparam int RES_W     = 4;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 2;
    localparam int COV_W     = 2;
    localparam int COUNT_W   = 17;

    // Shared multiplier and edge accumulator widths.
    localparam int MUL_W       = 34;
    localparam int PROD_W      = 2 * MUL_W;
    localparam int EDGE_W      = 56;
    localparam int QUERY_SHIFT = 28;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DRAW  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_RES_LOG2 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_EXT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TPM      = 2'd2;

    // Coverage classes.
    localparam logic [COV_W-1:0] COV_WATER = 2'd0;
    localparam logic [COV_W-1:0] COV_LAND  = 2'd1;
    localparam logic [COV_W-1:0] COV_MIXED = 2'd2;

    // Register values after reset.
    localparam logic [RES_W-1:0]  RES_LOG2_RESET = 4'd8;
    localparam logic [HALF_W-1:0] HALF_EXT_RESET = 24'd16000;
    localparam logic [TPM_W-1:0]  TPM_RESET      = 32'd2147484;

    typedef logic signed [MUL_W-1:0]  t_mop;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [EDGE_W-1:0] t_edge;

endpackage

FILE: hdl/tmr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tmr_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/tmr_mul.sv
// Shared signed multiplier with a registered product.
module tmr_mul (
    input  logic          i_clk,
    input  tmr_pkg::t_mop i_a,
    input  tmr_pkg::t_mop i_b,
    output tmr_pkg::t_prod o_prod
);

    tmr_pkg::t_prod r_prod;

    // One product per cycle, available the cycle after the operands.
    always_ff @(posedge i_clk) begin
        r_prod <= tmr_pkg::t_prod'(i_a) * tmr_pkg::t_prod'(i_b);
    end

    assign o_prod = r_prod;

endmodule

FILE: hdl/triangle_mask_rasterizer_top.sv
// Top level of the triangle mask rasterizer: sequencer, edge walker and mask.
// Draw: one texel per cycle after an edge setup on the shared multiplier; a box
//   wholly off the mask is rejected without a walk. Query: answered early when
//   the mask is all land or all water, the extent is zero or the point is outside.
// Clear: sweeps every mask address through the single RAM write port. One item
//   at a time; busy is high meanwhile. Reset (and every res_log2 write) starts
//   a clearing pass with busy high; the one-cycle result strobe is not stalled.
module triangle_mask_rasterizer_top #(
    parameter int MAX_RES_LOG2    = 8,
    parameter int COORD_FRAC_BITS = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    output logic                              o_busy,
    input  logic [tmr_pkg::CMD_W-1:0]         i_cmd,
    input  logic signed [tmr_pkg::COORD_W-1:0] i_v0_x,
    input  logic signed [tmr_pkg::COORD_W-1:0] i_v0_y,
    input  logic signed [tmr_pkg::COORD_W-1:0] i_v1_x,
    input  logic signed [tmr_pkg::COORD_W-1:0] i_v1_y,
    input  logic signed [tmr_pkg::COORD_W-1:0] i_v2_x,
    input  logic signed [tmr_pkg::COORD_W-1:0] i_v2_y,
    input  logic signed [tmr_pkg::POS_W-1:0]  i_east_pos,
    input  logic signed [tmr_pkg::POS_W-1:0]  i_north_pos,
    output logic                              o_valid,
    output logic                              o_is_land,
    output logic [tmr_pkg::COV_W-1:0]         o_coverage,
    output logic [tmr_pkg::COUNT_W-1:0]       o_set_count,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [tmr_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [tmr_pkg::CFG_W-1:0]         i_cfg_data
);

    localparam int XW    = MAX_RES_LOG2;
    localparam int AW    = 2 * MAX_RES_LOG2;
    localparam int DEPTH = 1 << AW;
    localparam int TW    = AW + 1;
    localparam int LW    = $clog2(MAX_RES_LOG2 + 1);
    localparam int QW    = tmr_pkg::PROD_W - tmr_pkg::QUERY_SHIFT;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_CLR   = 4'd1;
    localparam logic [3:0] ST_BOX   = 4'd2;
    localparam logic [3:0] ST_EDGE  = 4'd3;
    localparam logic [3:0] ST_WALK  = 4'd4;
    localparam logic [3:0] ST_DRAIN = 4'd5;
    localparam logic [3:0] ST_QCHK  = 4'd6;
    localparam logic [3:0] ST_QMUL  = 4'd7;
    localparam logic [3:0] ST_QRESP = 4'd8;

    logic [3:0]                        r_state;
    logic [2:0]                        r_step;
    logic signed [tmr_pkg::COORD_W-1:0] r_vx [3];
    logic signed [tmr_pkg::COORD_W-1:0] r_vy [3];
    logic signed [tmr_pkg::POS_W-1:0]  r_e;
    logic signed [tmr_pkg::POS_W-1:0]  r_n;
    logic [tmr_pkg::RES_W-1:0]         r_res;
    logic [tmr_pkg::HALF_W-1:0]        r_half;
    logic [tmr_pkg::TPM_W-1:0]         r_tpm;
    logic [TW-1:0]                     r_total;
    logic [AW-1:0]                     r_clr_addr;
    logic                              r_clr_resp;
    logic [XW-1:0]                     r_x0, r_x1, r_y1, r_cx, r_cy;
    logic [XW-1:0]                     r_qx;
    tmr_pkg::t_edge                    r_edge [3];
    tmr_pkg::t_edge                    r_row  [3];
    logic                              r_chk;
    logic [AW-1:0]                     r_chk_addr;
    logic                              r_valid;
    logic                              r_is_land;

    logic [LW-1:0]             act;
    logic [XW-1:0]             res_m1;
    logic [TW-1:0]             all_count;
    logic [tmr_pkg::COV_W-1:0] cov;
    tmr_pkg::t_mop             vxd [3];
    tmr_pkg::t_mop             vyd [3];
    tmr_pkg::t_mop             dxd [3];
    tmr_pkg::t_mop             dyd [3];
    tmr_pkg::t_edge            stepx [3];
    tmr_pkg::t_edge            stepy [3];
    tmr_pkg::t_mop             px0, py0, lim;
    tmr_pkg::t_mop             mnx, mxx, mny, mxy;
    logic                      box_reject;
    logic [XW-1:0]             bx0, bx1, by0, by1;
    tmr_pkg::t_mop             eh, nh, hh;
    logic                      q_out;
    logic [QW-1:0]             q_val;
    logic [XW-1:0]             q_clamp;
    logic                      e_neg, e_pos, in_tri;
    logic                      walk_row_end, walk_last;
    tmr_pkg::t_mop             mul_a, mul_b;
    tmr_pkg::t_prod            mul_prod;
    logic                      ram_we, ram_wdata, ram_rdata;
    logic [AW-1:0]             ram_waddr, ram_raddr;
    logic                      cfg_wr, hit_write;

    // Clamp a non-negative value to the last texel.
    function automatic logic [XW-1:0] clamp_tex(tmr_pkg::t_mop v, logic [XW-1:0] m);
        return (v > tmr_pkg::t_mop'(m)) ? m : v[XW-1:0];
    endfunction

    // Linear texel address for the active resolution.
    function automatic logic [AW-1:0] tex_idx(logic [XW-1:0] cx, logic [XW-1:0] cy,
                                              logic [LW-1:0] sh);
        return (AW'(cy) << sh) + AW'(cx);
    endfunction

    // Active resolution, coverage class and mask limits.
    assign act = (r_res > tmr_pkg::RES_W'(MAX_RES_LOG2)) ? LW'(MAX_RES_LOG2)
                                                         : r_res[LW-1:0];
    assign res_m1    = ~({XW{1'b1}} << act);
    assign all_count = TW'(1) << {act, 1'b0};
    assign lim = (tmr_pkg::t_mop'(res_m1) + tmr_pkg::t_mop'(1)) <<< COORD_FRAC_BITS;
    assign cov = (r_total == '0) ? tmr_pkg::COV_WATER :
                 (r_total == all_count) ? tmr_pkg::COV_LAND : tmr_pkg::COV_MIXED;

    // Doubled vertices, edge deltas and per-texel edge increments.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            vxd[k] = tmr_pkg::t_mop'(r_vx[k]) <<< 1;
            vyd[k] = tmr_pkg::t_mop'(r_vy[k]) <<< 1;
        end
        for (int k = 0; k < 3; k++) begin
            dxd[k]   = vxd[(k == 2) ? 0 : k + 1] - vxd[k];
            dyd[k]   = vyd[(k == 2) ? 0 : k + 1] - vyd[k];
            stepx[k] = -(tmr_pkg::t_edge'(dyd[k]) <<< (COORD_FRAC_BITS + 1));
            stepy[k] = tmr_pkg::t_edge'(dxd[k]) <<< (COORD_FRAC_BITS + 1);
        end
    end

    // Center of the first texel of the box, doubled.
    assign px0 = tmr_pkg::t_mop'({r_x0, 1'b1}) <<< COORD_FRAC_BITS;
    assign py0 = tmr_pkg::t_mop'({by0, 1'b1}) <<< COORD_FRAC_BITS;

    // Bounding box, rejection and clamping.
    always_comb begin
        mnx = tmr_pkg::t_mop'(r_vx[0]);
        mxx = mnx;
        mny = tmr_pkg::t_mop'(r_vy[0]);
        mxy = mny;
        for (int k = 1; k < 3; k++) begin
            if (tmr_pkg::t_mop'(r_vx[k]) < mnx) mnx = tmr_pkg::t_mop'(r_vx[k]);
            if (tmr_pkg::t_mop'(r_vx[k]) > mxx) mxx = tmr_pkg::t_mop'(r_vx[k]);
            if (tmr_pkg::t_mop'(r_vy[k]) < mny) mny = tmr_pkg::t_mop'(r_vy[k]);
            if (tmr_pkg::t_mop'(r_vy[k]) > mxy) mxy = tmr_pkg::t_mop'(r_vy[k]);
        end
        box_reject = (mxx < 0) || (mxy < 0) || (mnx >= lim) || (mny >= lim);
        bx0 = clamp_tex((mnx < 0) ? '0 : (mnx >>> COORD_FRAC_BITS), res_m1);
        by0 = clamp_tex((mny < 0) ? '0 : (mny >>> COORD_FRAC_BITS), res_m1);
        bx1 = clamp_tex((mxx + tmr_pkg::t_mop'((1 << COORD_FRAC_BITS) - 1))
                        >>> COORD_FRAC_BITS, res_m1);
        by1 = clamp_tex((mxy + tmr_pkg::t_mop'((1 << COORD_FRAC_BITS) - 1))
                        >>> COORD_FRAC_BITS, res_m1);
    end

    // Query offsets and extent test.
    assign hh = tmr_pkg::t_mop'(r_half);
    assign eh = tmr_pkg::t_mop'(r_e) + hh;
    assign nh = tmr_pkg::t_mop'(r_n) + hh;
    assign q_out = (tmr_pkg::t_mop'(r_e) < -hh) || (tmr_pkg::t_mop'(r_e) > hh) ||
                   (tmr_pkg::t_mop'(r_n) < -hh) || (tmr_pkg::t_mop'(r_n) > hh);
    assign q_val   = mul_prod[tmr_pkg::PROD_W-1:tmr_pkg::QUERY_SHIFT];
    assign q_clamp = (q_val > QW'(res_m1)) ? res_m1 : q_val[XW-1:0];

    // Edge sign test at the current texel.
    assign e_neg  = (r_edge[0] < 0) || (r_edge[1] < 0) || (r_edge[2] < 0);
    assign e_pos  = (r_edge[0] > 0) || (r_edge[1] > 0) || (r_edge[2] > 0);
    assign in_tri = !(e_neg && e_pos);
    assign walk_row_end = (r_cx == r_x1);
    assign walk_last    = walk_row_end && (r_cy == r_y1);

    // Operand selection for the shared multiplier.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (r_state == ST_EDGE) begin
            case (r_step)
                3'd0: begin mul_a = dxd[0]; mul_b = py0 - vyd[0]; end
                3'd1: begin mul_a = dyd[0]; mul_b = px0 - vxd[0]; end
                3'd2: begin mul_a = dxd[1]; mul_b = py0 - vyd[1]; end
                3'd3: begin mul_a = dyd[1]; mul_b = px0 - vxd[1]; end
                3'd4: begin mul_a = dxd[2]; mul_b = py0 - vyd[2]; end
                3'd5: begin mul_a = dyd[2]; mul_b = px0 - vxd[2]; end
                default: begin mul_a = '0; mul_b = '0; end
            endcase
        end else if (r_state == ST_QMUL) begin
            mul_a = (r_step == 3'd0) ? eh : nh;
            mul_b = tmr_pkg::t_mop'(r_tpm);
        end
    end

    tmr_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (mul_prod)
    );

    // Mask port control: clearing sweep or set of a texel found still clear.
    assign hit_write = r_chk && !ram_rdata;
    assign ram_we    = (r_state == ST_CLR) || hit_write;
    assign ram_waddr = (r_state == ST_CLR) ? r_clr_addr : r_chk_addr;
    assign ram_wdata = (r_state != ST_CLR);
    assign ram_raddr = (r_state == ST_QMUL) ? tex_idx(r_qx, q_clamp, act)
                                            : tex_idx(r_cx, r_cy, act);

    tmr_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_mask (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign cfg_wr = i_cfg_valid && o_cfg_ready;

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLR;
            r_step     <= '0;
            r_clr_addr <= '0;
            r_clr_resp <= 1'b0;
            r_total    <= '0;
            r_res      <= tmr_pkg::RES_LOG2_RESET;
            r_half     <= tmr_pkg::HALF_EXT_RESET;
            r_tpm      <= tmr_pkg::TPM_RESET;
            r_chk      <= 1'b0;
            r_valid    <= 1'b0;
            r_is_land  <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            r_chk   <= 1'b0;
            if (hit_write) begin
                r_total <= r_total + TW'(1);
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_start) begin
                        r_vx[0] <= i_v0_x;
                        r_vy[0] <= i_v0_y;
                        r_vx[1] <= i_v1_x;
                        r_vy[1] <= i_v1_y;
                        r_vx[2] <= i_v2_x;
                        r_vy[2] <= i_v2_y;
                        r_e     <= i_east_pos;
                        r_n     <= i_north_pos;
                        r_step  <= '0;
                        case (i_cmd)
                            tmr_pkg::CMD_CLEAR: begin
                                r_state    <= ST_CLR;
                                r_clr_addr <= '0;
                                r_clr_resp <= 1'b1;
                                r_total    <= '0;
                            end
                            tmr_pkg::CMD_DRAW:  r_state <= ST_BOX;
                            tmr_pkg::CMD_QUERY: r_state <= ST_QCHK;
                            default: begin
                                r_valid   <= 1'b1;
                                r_is_land <= 1'b0;
                            end
                        endcase
                    end
                end
                ST_CLR: begin
                    r_clr_addr <= r_clr_addr + AW'(1);
                    if (r_clr_addr == {AW{1'b1}}) begin
                        r_state   <= ST_IDLE;
                        r_valid   <= r_clr_resp;
                        r_is_land <= 1'b0;
                    end
                end
                ST_BOX: begin
                    if (box_reject) begin
                        r_state   <= ST_IDLE;
                        r_valid   <= 1'b1;
                        r_is_land <= 1'b0;
                    end else begin
                        r_x0    <= bx0;
                        r_x1    <= bx1;
                        r_y1    <= by1;
                        r_cx    <= bx0;
                        r_cy    <= by0;
                        r_step  <= '0;
                        r_state <= ST_EDGE;
                    end
                end
                ST_EDGE: begin
                    // Each edge value is two products accumulated in turn.
                    r_step <= r_step + 3'd1;
                    case (r_step)
                        3'd1: r_edge[0] <= mul_prod[tmr_pkg::EDGE_W-1:0];
                        3'd2: r_edge[0] <= r_edge[0] - mul_prod[tmr_pkg::EDGE_W-1:0];
                        3'd3: r_edge[1] <= mul_prod[tmr_pkg::EDGE_W-1:0];
                        3'd4: r_edge[1] <= r_edge[1] - mul_prod[tmr_pkg::EDGE_W-1:0];
                        3'd5: r_edge[2] <= mul_prod[tmr_pkg::EDGE_W-1:0];
                        3'd6: begin
                            r_edge[2] <= r_edge[2] - mul_prod[tmr_pkg::EDGE_W-1:0];
                            r_row[0]  <= r_edge[0];
                            r_row[1]  <= r_edge[1];
                            r_row[2]  <= r_edge[2] - mul_prod[tmr_pkg::EDGE_W-1:0];
                            r_state   <= ST_WALK;
                        end
                        default: begin
                        end
                    endcase
                end
                ST_WALK: begin
                    // Read the texel now, set it next cycle if it lies in the triangle and was clear.
                    r_chk      <= in_tri;
                    r_chk_addr <= tex_idx(r_cx, r_cy, act);
                    if (walk_last) begin
                        r_state <= ST_DRAIN;
                    end else if (walk_row_end) begin
                        r_cx <= r_x0;
                        r_cy <= r_cy + XW'(1);
                        for (int k = 0; k < 3; k++) begin
                            r_row[k]  <= r_row[k] + stepy[k];
                            r_edge[k] <= r_row[k] + stepy[k];
                        end
                    end else begin
                        r_cx <= r_cx + XW'(1);
                        for (int k = 0; k < 3; k++) begin
                            r_edge[k] <= r_edge[k] + stepx[k];
                        end
                    end
                end
                ST_DRAIN: begin
                    r_state   <= ST_IDLE;
                    r_valid   <= 1'b1;
                    r_is_land <= 1'b0;
                end
                ST_QCHK: begin
                    if ((r_half == '0) || (cov != tmr_pkg::COV_MIXED) || q_out) begin
                        r_state   <= ST_IDLE;
                        r_valid   <= 1'b1;
                        r_is_land <= (r_half != '0) && (cov == tmr_pkg::COV_LAND);
                    end else begin
                        r_step  <= '0;
                        r_state <= ST_QMUL;
                    end
                end
                ST_QMUL: begin
                    r_step <= r_step + 3'd1;
                    if (r_step == 3'd1) begin
                        r_qx <= q_clamp;
                    end
                    if (r_step == 3'd2) begin
                        r_state <= ST_QRESP;
                    end
                end
                ST_QRESP: begin
                    r_state   <= ST_IDLE;
                    r_valid   <= 1'b1;
                    r_is_land <= ram_rdata;
                end
                default: r_state <= ST_IDLE;
            endcase

            // Register writes; a new resolution restarts the clearing sweep.
            if (cfg_wr) begin
                case (i_cfg_index)
                    tmr_pkg::CFG_RES_LOG2: begin
                        r_res      <= i_cfg_data[tmr_pkg::RES_W-1:0];
                        r_state    <= ST_CLR;
                        r_clr_addr <= '0;
                        r_clr_resp <= 1'b0;
                        r_total    <= '0;
                    end
                    tmr_pkg::CFG_HALF_EXT: r_half <= i_cfg_data[tmr_pkg::HALF_W-1:0];
                    tmr_pkg::CFG_TPM:      r_tpm  <= i_cfg_data[tmr_pkg::TPM_W-1:0];
                    default: r_tpm <= r_tpm;
                endcase
            end
        end
    end

    // Registers are written only at rest and never beside a new item.
    assign o_busy      = (r_state != ST_IDLE);
    assign o_cfg_ready = (r_state == ST_IDLE) && !i_start;
    assign o_valid     = r_valid;
    assign o_is_land   = r_is_land;
    assign o_coverage  = cov;
    assign o_set_count = tmr_pkg::COUNT_W'(r_total);

    // A result is only shown once the sequencer is back at rest.
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_state == ST_IDLE))
        else $error("result strobe while sequencer active");

    // The set count never exceeds the texels of the active mask.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= all_count)
        else $error("set count above mask size");

    // An accepted item either answers at once or keeps the block busy.
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && !cfg_wr) |=> (o_busy || r_valid))
        else $error("accepted item neither busy nor answered");

    // The mask is never written while the block is at rest.
    a_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state != ST_IDLE))
        else $error("mask write while idle");

endmodule

FILE: tb/tmr_checker.sv
// Checker of the triangle mask rasterizer: predicts every result and compares it.
module tmr_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic                               i_busy,
    input  logic [tmr_pkg::CMD_W-1:0]          i_cmd,
    input  logic signed [tmr_pkg::COORD_W-1:0] i_v0_x,
    input  logic signed [tmr_pkg::COORD_W-1:0] i_v0_y,
    input  logic signed [tmr_pkg::COORD_W-1:0] i_v1_x,
    input  logic signed [tmr_pkg::COORD_W-1:0] i_v1_y,
    input  logic signed [tmr_pkg::COORD_W-1:0] i_v2_x,
    input  logic signed [tmr_pkg::COORD_W-1:0] i_v2_y,
    input  logic signed [tmr_pkg::POS_W-1:0]   i_east_pos,
    input  logic signed [tmr_pkg::POS_W-1:0]   i_north_pos,
    input  logic                               i_valid,
    input  logic                               i_is_land,
    input  logic [tmr_pkg::COV_W-1:0]          i_coverage,
    input  logic [tmr_pkg::COUNT_W-1:0]        i_set_count,
    input  logic                               i_cfg_valid,
    input  logic                               i_cfg_ready,
    input  logic [tmr_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [tmr_pkg::CFG_W-1:0]          i_cfg_data,
    output int                                 o_errors,
    output int                                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import tmr_pkg::*;

    localparam int MAX_LOG2 = 8;
    localparam int FRAC     = 8;
    localparam int TEXELS   = 1 << (2 * MAX_LOG2);

    typedef struct packed {
        logic               is_land;
        logic [COV_W-1:0]   coverage;
        logic [COUNT_W-1:0] set_count;
    } t_answer;

    logic [RES_W-1:0]  res_q;
    logic [HALF_W-1:0] half_q;
    logic [TPM_W-1:0]  tpm_q;
    logic              mask_q [TEXELS];
    int unsigned       land_cnt;
    t_answer           answer_fifo [$];

    function automatic int active_log2();
        return (res_q > MAX_LOG2) ? MAX_LOG2 : int'(res_q);
    endfunction

    function automatic void wipe_mask();
        for (int i = 0; i < TEXELS; i++) mask_q[i] = 1'b0;
        land_cnt = 0;
    endfunction

    function automatic logic [COV_W-1:0] coverage_of();
        longint all_tex;
        all_tex = longint'(1) << (2 * active_log2());
        if (land_cnt == 0) return COV_WATER;
        if (longint'(land_cnt) == all_tex) return COV_LAND;
        return COV_MIXED;
    endfunction

    function automatic longint edge_fn(longint ax, longint ay, longint bx, longint by,
                                       longint px, longint py);
        return (bx - ax) * (py - ay) - (by - ay) * (px - ax);
    endfunction

    // Set every texel of the clamped box whose center lies on the triangle.
    function automatic void paint_triangle(longint ax, longint ay, longint bx,
                                           longint by, longint cx, longint cy);
        longint r, lim, mnx, mxx, mny, mxy, x0, x1, y0, y1, px, py, e0, e1, e2;
        int     lg, idx;
        bit     neg, pos;
        lg  = active_log2();
        r   = longint'(1) << lg;
        lim = r << FRAC;
        mnx = ax; mxx = ax; mny = ay; mxy = ay;
        if (bx < mnx) mnx = bx;
        if (cx < mnx) mnx = cx;
        if (bx > mxx) mxx = bx;
        if (cx > mxx) mxx = cx;
        if (by < mny) mny = by;
        if (cy < mny) mny = cy;
        if (by > mxy) mxy = by;
        if (cy > mxy) mxy = cy;
        if (mxx < 0 || mxy < 0 || mnx >= lim || mny >= lim) return;
        x0 = (mnx < 0) ? 0 : (mnx >>> FRAC);
        y0 = (mny < 0) ? 0 : (mny >>> FRAC);
        x1 = (mxx + (1 << FRAC) - 1) >>> FRAC;
        y1 = (mxy + (1 << FRAC) - 1) >>> FRAC;
        if (x0 > r - 1) x0 = r - 1;
        if (y0 > r - 1) y0 = r - 1;
        if (x1 > r - 1) x1 = r - 1;
        if (y1 > r - 1) y1 = r - 1;
        ax *= 2; ay *= 2; bx *= 2; by *= 2; cx *= 2; cy *= 2;
        for (longint y = y0; y <= y1; y++) begin
            py = (2 * y + 1) << FRAC;
            for (longint x = x0; x <= x1; x++) begin
                px  = (2 * x + 1) << FRAC;
                e0  = edge_fn(ax, ay, bx, by, px, py);
                e1  = edge_fn(bx, by, cx, cy, px, py);
                e2  = edge_fn(cx, cy, ax, ay, px, py);
                neg = (e0 < 0) || (e1 < 0) || (e2 < 0);
                pos = (e0 > 0) || (e1 > 0) || (e2 > 0);
                if (!(neg && pos)) begin
                    idx = int'((y << lg) + x);
                    if (!mask_q[idx]) begin
                        mask_q[idx] = 1'b1;
                        land_cnt++;
                    end
                end
            end
        end
    endfunction

    // Land lookup of a signed east/north position.
    function automatic logic lookup_land(longint e, longint n);
        longint h, r, x, y;
        logic [COV_W-1:0] cov;
        h   = longint'(half_q);
        cov = coverage_of();
        r   = longint'(1) << active_log2();
        if (h == 0) return 1'b0;
        if (cov == COV_LAND) return 1'b1;
        if (cov == COV_WATER) return 1'b0;
        if (e < -h || e > h || n < -h || n > h) return 1'b0;
        x = ((e + h) * longint'(tpm_q)) >>> QUERY_SHIFT;
        y = ((n + h) * longint'(tpm_q)) >>> QUERY_SHIFT;
        if (x > r - 1) x = r - 1;
        if (y > r - 1) y = r - 1;
        return mask_q[int'((y << active_log2()) + x)];
    endfunction

    // Compare results, track register writes and predict accepted items.
    always @(posedge i_clk) begin
        t_answer got, want;
        if (!i_rst_n) begin
            res_q  = RES_LOG2_RESET;
            half_q = HALF_EXT_RESET;
            tpm_q  = TPM_RESET;
            wipe_mask();
            answer_fifo.delete();
            o_errors  <= 0;
            o_pending <= 0;
        end else begin
            if (i_valid) begin
                got = '{i_is_land, i_coverage, i_set_count};
                if (answer_fifo.size() == 0) begin
                    $error("result with no item outstanding");
                    o_errors <= o_errors + 1;
                end else begin
                    want = answer_fifo.pop_front();
                    if (got.is_land !== want.is_land)
                        $error("is_land: expected %0d, actual %0d", want.is_land, got.is_land);
                    if (got.coverage !== want.coverage)
                        $error("coverage: expected %0d, actual %0d",
                               want.coverage, got.coverage);
                    if (got.set_count !== want.set_count)
                        $error("set_count: expected %0d, actual %0d",
                               want.set_count, got.set_count);
                    if (got !== want) o_errors <= o_errors + 1;
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_RES_LOG2: begin
                        res_q = i_cfg_data[RES_W-1:0];
                        wipe_mask();
                    end
                    CFG_HALF_EXT: half_q = i_cfg_data[HALF_W-1:0];
                    CFG_TPM:      tpm_q  = i_cfg_data[TPM_W-1:0];
                    default: ;
                endcase
            end
            if (i_start && !i_busy) begin
                want.is_land = 1'b0;
                case (i_cmd)
                    CMD_CLEAR: wipe_mask();
                    CMD_DRAW:  paint_triangle(i_v0_x, i_v0_y, i_v1_x, i_v1_y,
                                              i_v2_x, i_v2_y);
                    CMD_QUERY: want.is_land = lookup_land(i_east_pos, i_north_pos);
                    default: ;
                endcase
                want.coverage  = coverage_of();
                want.set_count = land_cnt[COUNT_W-1:0];
                answer_fifo.push_back(want);
            end
            o_pending <= answer_fifo.size();
        end
    end
endmodule

FILE: tb/tb.sv
// Testbench top of the triangle mask rasterizer: stimulus, watchdog and verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import tmr_pkg::*;

    localparam int WATCHDOG = 400000;

    // Command code that the block leaves unused.
    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_start = 1'b0;
    logic               o_busy;
    logic [CMD_W-1:0]   i_cmd = CMD_CLEAR;
    logic signed [COORD_W-1:0] i_v0_x = '0, i_v0_y = '0, i_v1_x = '0;
    logic signed [COORD_W-1:0] i_v1_y = '0, i_v2_x = '0, i_v2_y = '0;
    logic signed [POS_W-1:0]   i_east_pos = '0, i_north_pos = '0;
    logic               o_valid, o_is_land, o_cfg_ready;
    logic [COV_W-1:0]   o_coverage;
    logic [COUNT_W-1:0] o_set_count;
    logic               i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_RES_LOG2;
    logic [CFG_W-1:0]   i_cfg_data = '0;
    int                 errors, pending;

    int unsigned res_now = 8, half_now = 16000;
    int          item_no = 0, phases = 0, n_draw = 0, n_query = 0;
    bit          calm = 1'b0;
    int          quiet_cnt = 0;

    always #1 i_clk = ~i_clk;

    triangle_mask_rasterizer_top dut (.*);

    tmr_checker u_chk (
        .i_clk, .i_rst_n, .i_start, .i_busy(o_busy), .i_cmd,
        .i_v0_x, .i_v0_y, .i_v1_x, .i_v1_y, .i_v2_x, .i_v2_y,
        .i_east_pos, .i_north_pos, .i_valid(o_valid), .i_is_land(o_is_land),
        .i_coverage(o_coverage), .i_set_count(o_set_count),
        .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index, .i_cfg_data,
        .o_errors(errors), .o_pending(pending)
    );

    // Watchdog on cycles in which nothing at all is accepted and no result appears.
    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || (i_cfg_valid && o_cfg_ready) || o_valid || !i_rst_n)
            quiet_cnt <= 0;
        else
            quiet_cnt <= quiet_cnt + 1;
        if (quiet_cnt >= WATCHDOG) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Random coordinate word.
    function automatic logic [COORD_W-1:0] rnd_c();
        return COORD_W'($urandom);
    endfunction

    // Random pause before an item, skipped during the calm stretch.
    task automatic maybe_pause();
        if (!calm && $urandom_range(0, 99) < 13) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    // Present one item and hold it until the block takes it.
    task automatic send_item(logic [CMD_W-1:0] cmd,
                             logic [COORD_W-1:0] ax, logic [COORD_W-1:0] ay,
                             logic [COORD_W-1:0] bx, logic [COORD_W-1:0] by,
                             logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cy,
                             logic [POS_W-1:0] e, logic [POS_W-1:0] n);
        maybe_pause();
        i_start <= 1'b1;
        i_cmd <= cmd;
        i_v0_x <= ax; i_v0_y <= ay; i_v1_x <= bx;
        i_v1_y <= by; i_v2_x <= cx; i_v2_y <= cy;
        i_east_pos <= e; i_north_pos <= n;
        @(negedge i_clk);
        while (o_busy) @(negedge i_clk);
        @(posedge i_clk);
        item_no++;
        if (cmd == CMD_DRAW) n_draw++;
        if (cmd == CMD_QUERY) n_query++;
    endtask

    task automatic draw_px(int ax, int ay, int bx, int by, int cx, int cy);
        send_item(CMD_DRAW, COORD_W'(ax * 256), COORD_W'(ay * 256), COORD_W'(bx * 256),
                  COORD_W'(by * 256), COORD_W'(cx * 256), COORD_W'(cy * 256),
                  $urandom, $urandom);
    endtask

    task automatic ask(int e, int n);
        send_item(CMD_QUERY, rnd_c(), rnd_c(), rnd_c(), rnd_c(), rnd_c(), rnd_c(),
                  e, n);
    endtask

    // Register write, made only once every result is in.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        i_start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        while (!o_cfg_ready) @(negedge i_clk);
        @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_RES_LOG2) res_now = data[RES_W-1:0];
        if (idx == CFG_HALF_EXT) half_now = data[HALF_W-1:0];
    endtask

    task automatic set_phase(int unsigned res, int unsigned half, int unsigned tpm);
        write_reg(CFG_RES_LOG2, res);
        write_reg(CFG_HALF_EXT, half);
        write_reg(CFG_TPM, tpm);
        phases++;
    endtask

    // One random item shaped to land mostly on or near the mask.
    task automatic random_item();
        int unsigned roll, side;
        int          bxp, byp, span;
        logic [COORD_W-1:0] c [6];
        longint      h, e, n;
        roll = $urandom_range(0, 999);
        side = 1 << ((res_now > 8) ? 8 : res_now);
        if (roll < 4) begin
            send_item(CMD_CLEAR, rnd_c(), rnd_c(), rnd_c(), rnd_c(), rnd_c(),
                      rnd_c(), $urandom, $urandom);
        end else if (roll < 24) begin
            send_item(CMD_SPARE, rnd_c(), rnd_c(), rnd_c(), rnd_c(), rnd_c(),
                      rnd_c(), $urandom, $urandom);
        end else if (roll < 80) begin
            // Wide noise vertices whose box lies wholly off the mask.
            for (int i = 0; i < 6; i++) c[i] = rnd_c();
            if ($urandom_range(0, 1)) begin
                c[0][23] = 1'b1; c[2][23] = 1'b1; c[4][23] = 1'b1;
            end else begin
                c[1][23:22] = 2'b01; c[3][23:22] = 2'b01; c[5][23:22] = 2'b01;
            end
            send_item(CMD_DRAW, c[0], c[1], c[2], c[3], c[4], c[5], $urandom, $urandom);
        end else if (roll < 560) begin
            bxp  = $urandom_range(0, side + 16) - 8;
            byp  = $urandom_range(0, side + 16) - 8;
            span = 256 * $urandom_range(1, 12);
            for (int i = 0; i < 6; i++)
                c[i] = COORD_W'(((i % 2) ? byp : bxp) * 256
                                + int'($urandom_range(0, 2 * span)) - span);
            if (roll < 110) begin
                // Collinear vertices: the middle one halfway between the others.
                c[2] = COORD_W'((longint'($signed(c[0])) + longint'($signed(c[4]))) >>> 1);
                c[3] = COORD_W'((longint'($signed(c[1])) + longint'($signed(c[5]))) >>> 1);
            end
            send_item(CMD_DRAW, c[0], c[1], c[2], c[3], c[4], c[5], $urandom, $urandom);
        end else if (roll < 600) begin
            ask($urandom, $urandom);
        end else begin
            h = half_now;
            e = longint'($urandom_range(0, 2 * h + h / 4 + 4)) - h - h / 8 - 2;
            n = longint'($urandom_range(0, 2 * h + h / 4 + 4)) - h - h / 8 - 2;
            ask(int'(e), int'(n));
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed items under the reset settings.
        ask(0, 0);
        draw_px(10, 10, 20, 10, 10, 20);
        ask(0, 0);
        ask(-16000, 16000);
        ask(16001, 0);
        ask(32'sh8000_0000, 32'sh7fff_ffff);
        ask(-15000, -15000);
        draw_px(5, 5, 10, 10, 15, 15);
        draw_px(-40, 3, -20, 8, -30, 60);
        draw_px(3, 300, 8, 260, 60, 270);
        send_item(CMD_SPARE, '1, '0, '1, '0, '1, '0, '1, '0);
        send_item(CMD_DRAW, 24'h800000, 24'h800000, 24'h7fffff, 24'h800000,
                  24'h000000, 24'h7fffff, $urandom, $urandom);
        ask(32'sh7fff_ffff, 32'sh8000_0000);
        send_item(CMD_CLEAR, '0, '0, '0, '0, '0, '0, '0, '0);
        ask(100, 100);

        // Small mask filled completely, then zero extent.
        set_phase(4, 256, 32'd8388608);
        draw_px(0, 0, 64, 0, 0, 64);
        ask(10000, -10000);
        draw_px(2, 2, 4, 2, 2, 4);
        write_reg(CFG_HALF_EXT, 0);
        ask(0, 0);
        write_reg(CFG_RES_LOG2, 4);
        draw_px(1, 1, 9, 2, 3, 12);
        ask(0, 0);

        // Random phases across extreme and typical settings.
        for (int p = 0; p < 6; p++) begin
            case (p)
                0: set_phase(4, 256, 32'd8388608);
                1: set_phase(11, 24'hffffff, 32'd1);
                2: set_phase(5, 1, 32'hffffffff);
                3: set_phase(8, 16000, 32'd2147484);
                4: set_phase(6, 1000, 32'd8589935);
                default: set_phase($urandom_range(4, 11), $urandom_range(1, 24'hffffff),
                                   $urandom_range(1, 32'hffffffff));
            endcase
            calm = (p == 3);
            repeat (165) random_item();
            calm = 1'b0;
        end

        i_start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        $display("Ran %0d items (%0d draws, %0d queries) over %0d register settings.",
                 item_no, n_draw, n_query, phases);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
